### src/assert_macros.svh
// Assertion macros for the RTL of the text buffer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge out of reset.
`define LTB_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ltb check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define LTB_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ltb check failed");

`endif

### src/ltb_pkg.sv
// Command codes and fixed field widths of the line-indexed text buffer.
package ltb_pkg;

  localparam int CMD_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int LINE_W  = 8;
  localparam int COL_W   = 8;
  localparam int OFF_W   = 9;
  localparam int LCNT_W  = 7;
  localparam int TLEN_W  = 10;
  localparam int YLEN_W  = 6;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 4'd0,
    CMD_APPEND   = 4'd1,
    CMD_READ     = 4'd2,
    CMD_YREAD    = 4'd3,
    CMD_INS_CHAR = 4'd4,
    CMD_DEL_CHAR = 4'd5,
    CMD_SPLIT    = 4'd6,
    CMD_JOIN     = 4'd7,
    CMD_DEL_LINE = 4'd8,
    CMD_INS_LINE = 4'd9
  } cmd_t;

endpackage

### src/ltb_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module ltb_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/line_indexed_text_buffer_core.sv
// Line-indexed text buffer: command sequencer around the text, line-table and yank RAMs.
// One command is taken at a time and answers with one result. An edit reads the line
// start from the line table, scans the text RAM one byte per cycle to the end of the
// addressed line, moves the tail of the text one byte per cycle through the text RAM's
// read and write ports (a line delete first copies up to YANK_CAPACITY bytes to the yank
// RAM), and then rescans the whole text one byte per cycle to rebuild the line table.
`include "assert_macros.svh"

module line_indexed_text_buffer_core #(
  parameter int TEXT_CAPACITY = 512,
  parameter int MAX_LINES     = 64,
  parameter int YANK_CAPACITY = 63
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ltb_pkg::CMD_W-1:0]   in_command,
  input  logic [ltb_pkg::LINE_W-1:0]  in_line_number,
  input  logic [ltb_pkg::COL_W-1:0]   in_column,
  input  logic [ltb_pkg::BYTE_W-1:0]  in_char_in,
  input  logic [ltb_pkg::OFF_W-1:0]   in_read_offset,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ok,
  output logic [ltb_pkg::BYTE_W-1:0]  out_byte_out,
  output logic [ltb_pkg::LCNT_W-1:0]  out_line_count,
  output logic [ltb_pkg::TLEN_W-1:0]  out_text_length,
  output logic [ltb_pkg::YLEN_W-1:0]  out_yank_length,
  output logic                        out_modified
);

  import ltb_pkg::*;

  localparam int PW  = $clog2(TEXT_CAPACITY + 1);
  localparam int AW  = $clog2(TEXT_CAPACITY);
  localparam int EW  = $clog2(TEXT_CAPACITY + 257);
  localparam int NW  = $clog2(MAX_LINES + 1);
  localparam int LW  = $clog2(MAX_LINES);
  localparam int YW  = $clog2(YANK_CAPACITY + 1);
  localparam int YAW = (YANK_CAPACITY > 1) ? $clog2(YANK_CAPACITY) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_RD, S_YRD, S_START, S_FIND, S_EXEC,
    S_GAP, S_DEL, S_YANK, S_SCAN, S_DONE
  } state_t;

  state_t            state_r;
  cmd_t              cmd_r;
  logic [LINE_W-1:0] line_r;
  logic [COL_W-1:0]  col_r;
  logic [BYTE_W-1:0] ch_r;
  logic [OFF_W-1:0]  off_r;

  logic [PW-1:0]     len_r;
  logic [NW-1:0]     lines_r;
  logic [YW-1:0]     ylen_r;
  logic              mod_r;

  logic [PW-1:0]     start_r;
  logic [PW-1:0]     end_r;
  logic [EW-1:0]     p_r;
  logic [EW-1:0]     q_r;
  logic              qv_r;
  logic              first_r;
  logic [PW-1:0]     cnt_r;
  logic [PW-1:0]     a_r;
  logic [BYTE_W-1:0] b_r;
  logic [EW-1:0]     dcnt_r;
  logic [NW-1:0]     n_r;
  logic [YW-1:0]     yj_r;
  logic              ok_r;
  logic [BYTE_W-1:0] byte_r;

  logic              out_valid_r;
  logic              out_ok_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [LCNT_W-1:0] out_lcnt_r;
  logic [TLEN_W-1:0] out_tlen_r;
  logic [YLEN_W-1:0] out_ylen_r;
  logic              out_mod_r;

  logic              t_we;
  logic [AW-1:0]     t_waddr;
  logic [BYTE_W-1:0] t_wdata;
  logic [BYTE_W-1:0] t_rdata;
  logic              l_we;
  logic [PW-1:0]     l_wdata;
  logic [PW-1:0]     l_rdata;
  logic              y_we;
  logic [BYTE_W-1:0] y_rdata;

  logic [EW-1:0]     len_e;
  logic [EW-1:0]     end_e;
  logic [EW-1:0]     at_w;
  logic [EW-1:0]     span_w;
  logic [EW-1:0]     yl_w;
  logic [EW-1:0]     il_w;
  logic              full_w;
  logic              nl_hit;

  assign len_e  = EW'(len_r);
  assign end_e  = EW'(end_r);
  assign at_w   = EW'(start_r) + EW'(col_r);
  assign span_w = end_e - EW'(start_r);
  assign yl_w   = (span_w > EW'(YANK_CAPACITY)) ? EW'(YANK_CAPACITY) : span_w;
  assign il_w   = (end_e < len_e) ? end_e + EW'(1) : end_e;
  assign full_w = (32'(len_r) >= TEXT_CAPACITY);
  assign nl_hit = qv_r && (t_rdata == NEWLINE);

  // Memory write ports follow the sequencer state.
  always_comb begin
    t_we    = 1'b0;
    t_waddr = q_r[AW-1:0];
    t_wdata = t_rdata;
    l_we    = 1'b0;
    l_wdata = PW'(q_r + EW'(1));
    y_we    = 1'b0;
    case (state_r)
      S_CMD: begin
        if (cmd_r == CMD_APPEND && !full_w) begin
          t_we    = 1'b1;
          t_waddr = len_r[AW-1:0];
          t_wdata = ch_r;
        end
      end
      S_GAP: begin
        if (qv_r) begin
          t_we    = 1'b1;
          t_waddr = AW'(q_r + EW'(1));
        end else if (cnt_r == '0) begin
          t_we    = 1'b1;
          t_waddr = a_r[AW-1:0];
          t_wdata = b_r;
        end
      end
      S_DEL: begin
        if (qv_r) begin
          t_we    = 1'b1;
          t_waddr = AW'(q_r - dcnt_r);
        end
      end
      S_YANK: y_we = qv_r;
      S_SCAN: l_we = nl_hit && (32'(n_r) < MAX_LINES);
      default: ;
    endcase
  end

  ltb_ram #(.DEPTH(TEXT_CAPACITY), .WIDTH(BYTE_W), .AW(AW)) u_text (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (p_r[AW-1:0]),
    .rdata (t_rdata)
  );

  ltb_ram #(.DEPTH(MAX_LINES), .WIDTH(PW), .AW(LW)) u_lines (
    .clk   (clk),
    .we    (l_we),
    .waddr (n_r[LW-1:0]),
    .wdata (l_wdata),
    .raddr (line_r[LW-1:0]),
    .rdata (l_rdata)
  );

  ltb_ram #(.DEPTH(YANK_CAPACITY), .WIDTH(BYTE_W), .AW(YAW)) u_yank (
    .clk   (clk),
    .we    (y_we),
    .waddr (yj_r[YAW-1:0]),
    .wdata (t_rdata),
    .raddr (off_r[YAW-1:0]),
    .rdata (y_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      lines_r     <= NW'(1);
      ylen_r      <= '0;
      mod_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= cmd_t'(in_command);
            line_r  <= in_line_number;
            col_r   <= in_column;
            ch_r    <= in_char_in;
            off_r   <= in_read_offset;
            p_r     <= EW'(in_read_offset);
            ok_r    <= 1'b0;
            byte_r  <= '0;
            state_r <= S_CMD;
          end
        end
        S_CMD: begin
          case (cmd_r)
            CMD_CLEAR: begin
              len_r   <= '0;
              mod_r   <= 1'b0;
              lines_r <= NW'(1);
              ok_r    <= 1'b1;
              state_r <= S_DONE;
            end
            CMD_APPEND: begin
              if (!full_w) begin
                len_r   <= len_r + PW'(1);
                ok_r    <= 1'b1;
                p_r     <= '0;
                qv_r    <= 1'b0;
                first_r <= 1'b1;
                n_r     <= NW'(1);
                state_r <= S_SCAN;
              end else begin
                state_r <= S_DONE;
              end
            end
            CMD_READ: state_r <= (32'(off_r) < 32'(len_r)) ? S_RD : S_DONE;
            CMD_YREAD: state_r <= (32'(off_r) < 32'(ylen_r)) ? S_YRD : S_DONE;
            CMD_INS_CHAR, CMD_DEL_CHAR, CMD_SPLIT, CMD_JOIN, CMD_DEL_LINE,
            CMD_INS_LINE: begin
              if (32'(line_r) >= 32'(lines_r)) begin
                state_r <= S_DONE;
              end else if (line_r == '0) begin
                start_r <= '0;
                p_r     <= '0;
                qv_r    <= 1'b0;
                first_r <= 1'b1;
                state_r <= S_FIND;
              end else begin
                state_r <= S_START;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_RD: begin
          byte_r  <= t_rdata;
          ok_r    <= 1'b1;
          state_r <= S_DONE;
        end
        S_YRD: begin
          byte_r  <= y_rdata;
          ok_r    <= 1'b1;
          state_r <= S_DONE;
        end
        S_START: begin
          start_r <= l_rdata;
          p_r     <= EW'(l_rdata);
          qv_r    <= 1'b0;
          first_r <= 1'b1;
          state_r <= S_FIND;
        end
        S_FIND: begin
          // Stream reads and look for the newline closing the line.
          first_r <= 1'b0;
          qv_r    <= (p_r < len_e);
          q_r     <= p_r;
          if (p_r < len_e) begin
            p_r <= p_r + EW'(1);
          end
          if (nl_hit) begin
            end_r   <= PW'(q_r);
            state_r <= S_EXEC;
          end else if (!first_r && !qv_r) begin
            end_r   <= len_r;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          qv_r    <= 1'b0;
          first_r <= 1'b1;
          n_r     <= NW'(1);
          case (cmd_r)
            CMD_INS_CHAR, CMD_SPLIT, CMD_INS_LINE: begin
              if (cmd_r == CMD_INS_LINE) begin
                if (!full_w) begin
                  a_r     <= PW'(il_w);
                  p_r     <= len_e - EW'(1);
                  cnt_r   <= PW'(len_e - il_w);
                  b_r     <= NEWLINE;
                  ok_r    <= 1'b1;
                  mod_r   <= 1'b1;
                  state_r <= S_GAP;
                end else begin
                  state_r <= S_DONE;
                end
              end else if (!(at_w > end_e) && !full_w) begin
                a_r     <= PW'(at_w);
                p_r     <= len_e - EW'(1);
                cnt_r   <= PW'(len_e - at_w);
                b_r     <= (cmd_r == CMD_INS_CHAR) ? ch_r : NEWLINE;
                ok_r    <= 1'b1;
                mod_r   <= 1'b1;
                state_r <= S_GAP;
              end else begin
                state_r <= S_DONE;
              end
            end
            CMD_DEL_CHAR: begin
              if (at_w < end_e) begin
                p_r     <= at_w + EW'(1);
                dcnt_r  <= EW'(1);
                ok_r    <= 1'b1;
                mod_r   <= 1'b1;
                state_r <= S_DEL;
              end else begin
                state_r <= S_DONE;
              end
            end
            CMD_JOIN: begin
              if (32'(line_r) + 1 < 32'(lines_r)) begin
                ok_r  <= 1'b1;
                mod_r <= 1'b1;
                if (end_e < len_e) begin
                  p_r     <= end_e + EW'(1);
                  dcnt_r  <= EW'(1);
                  state_r <= S_DEL;
                end else begin
                  p_r     <= '0;
                  state_r <= S_SCAN;
                end
              end else begin
                state_r <= S_DONE;
              end
            end
            CMD_DEL_LINE: begin
              ylen_r  <= YW'(yl_w);
              cnt_r   <= PW'(yl_w);
              p_r     <= EW'(start_r);
              yj_r    <= '0;
              ok_r    <= 1'b1;
              mod_r   <= 1'b1;
              state_r <= S_YANK;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_GAP: begin
          // Move the tail up by one, last byte first, then drop in the new byte.
          if (cnt_r != '0) begin
            qv_r  <= 1'b1;
            q_r   <= p_r;
            p_r   <= p_r - EW'(1);
            cnt_r <= cnt_r - PW'(1);
          end else begin
            qv_r <= 1'b0;
            if (!qv_r) begin
              len_r   <= len_r + PW'(1);
              p_r     <= '0;
              first_r <= 1'b1;
              n_r     <= NW'(1);
              state_r <= S_SCAN;
            end
          end
        end
        S_DEL: begin
          if (p_r < len_e) begin
            qv_r <= 1'b1;
            q_r  <= p_r;
            p_r  <= p_r + EW'(1);
          end else begin
            qv_r <= 1'b0;
            if (!qv_r) begin
              len_r   <= (dcnt_r <= len_e) ? PW'(len_e - dcnt_r) : '0;
              p_r     <= '0;
              first_r <= 1'b1;
              n_r     <= NW'(1);
              state_r <= S_SCAN;
            end
          end
        end
        S_YANK: begin
          if (qv_r) begin
            yj_r <= yj_r + YW'(1);
          end
          if (cnt_r != '0) begin
            qv_r  <= 1'b1;
            p_r   <= p_r + EW'(1);
            cnt_r <= cnt_r - PW'(1);
          end else begin
            qv_r <= 1'b0;
            if (!qv_r) begin
              // Remove the line together with the byte after it.
              p_r     <= end_e + EW'(1);
              dcnt_r  <= span_w + EW'(1);
              state_r <= S_DEL;
            end
          end
        end
        S_SCAN: begin
          first_r <= 1'b0;
          qv_r    <= (p_r < len_e);
          q_r     <= p_r;
          if (p_r < len_e) begin
            p_r <= p_r + EW'(1);
          end
          if (nl_hit && (32'(n_r) < MAX_LINES)) begin
            n_r <= n_r + NW'(1);
          end
          if (!first_r && !qv_r) begin
            lines_r <= n_r;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= ok_r;
            out_byte_r  <= byte_r;
            out_lcnt_r  <= LCNT_W'(lines_r);
            out_tlen_r  <= TLEN_W'(len_r);
            out_ylen_r  <= YLEN_W'(ylen_r);
            out_mod_r   <= mod_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_byte_out    = out_byte_r;
  assign out_line_count  = out_lcnt_r;
  assign out_text_length = out_tlen_r;
  assign out_yank_length = out_ylen_r;
  assign out_modified    = out_mod_r;

  `LTB_CHECK(a_len_cap, 32'(len_r) <= TEXT_CAPACITY)
  `LTB_CHECK(a_lines_rng, lines_r != '0 && 32'(lines_r) <= MAX_LINES)
  `LTB_CHECK(a_ylen_cap, 32'(ylen_r) <= YANK_CAPACITY)
  `LTB_CHECK_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

endmodule

### dv/ltb_checker.sv
// Scoreboard for the text buffer: predicts each command's result and compares transfers.
`timescale 1ns / 100ps

module ltb_checker
  import ltb_pkg::*;
#(
  parameter int TEXT_CAPACITY = 512,
  parameter int MAX_LINES     = 64,
  parameter int YANK_CAPACITY = 63
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [LINE_W-1:0] in_line_number,
  input  logic [COL_W-1:0]  in_column,
  input  logic [BYTE_W-1:0] in_char_in,
  input  logic [OFF_W-1:0]  in_read_offset,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_ok,
  input  logic [BYTE_W-1:0] out_byte_out,
  input  logic [LCNT_W-1:0] out_line_count,
  input  logic [TLEN_W-1:0] out_text_length,
  input  logic [YLEN_W-1:0] out_yank_length,
  input  logic              out_modified,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] byte_out;
    logic [LCNT_W-1:0] line_count;
    logic [TLEN_W-1:0] text_length;
    logic [YLEN_W-1:0] yank_length;
    logic              modified;
  } status_t;

  logic [BYTE_W-1:0] text_mem [TEXT_CAPACITY];
  logic [BYTE_W-1:0] yank_mem [YANK_CAPACITY];
  int                line_base [MAX_LINES];
  int                n_lines, text_len, yank_cnt;
  logic              dirty;
  status_t           status_q [$];

  assign pending = status_q.size();

  function automatic void index_lines();
    int p, n;
    n = 1;
    line_base[0] = 0;
    for (p = 0; p < text_len && n < MAX_LINES; p++) begin
      if (text_mem[p] == NEWLINE) begin
        line_base[n] = p + 1;
        n++;
      end
    end
    n_lines = n;
  endfunction

  function automatic int end_of_line(int ln);
    int p;
    if (ln >= n_lines) return text_len;
    for (p = line_base[ln]; p < text_len; p++)
      if (text_mem[p] == NEWLINE) return p;
    return text_len;
  endfunction

  function automatic bit insert_byte(int at, logic [BYTE_W-1:0] b);
    int i;
    if (text_len >= TEXT_CAPACITY || at > text_len) return 0;
    for (i = text_len; i > at; i--) text_mem[i] = text_mem[i-1];
    text_mem[at] = b;
    text_len++;
    return 1;
  endfunction

  function automatic void cut_bytes(int at, int cnt);
    int i;
    for (i = at; i + cnt < text_len; i++) text_mem[i] = text_mem[i+cnt];
    text_len = (cnt <= text_len) ? text_len - cnt : 0;
  endfunction

  function automatic bit apply_edit(cmd_t cmd, int ln, int col, logic [BYTE_W-1:0] ch);
    int s, e, p, len, j;
    if (ln >= n_lines) return 0;
    s = line_base[ln];
    e = end_of_line(ln);
    case (cmd)
      CMD_INS_CHAR: if (s + col > e || !insert_byte(s + col, ch)) return 0;
      CMD_DEL_CHAR: begin
        p = s + col;
        if (p >= e || p >= text_len || text_mem[p] == NEWLINE) return 0;
        cut_bytes(p, 1);
      end
      CMD_SPLIT: if (col > e - s || !insert_byte(s + col, NEWLINE)) return 0;
      CMD_JOIN: begin
        if (ln + 1 >= n_lines) return 0;
        if (e < text_len && text_mem[e] == NEWLINE) cut_bytes(e, 1);
      end
      CMD_DEL_LINE: begin
        len = e - s;
        yank_cnt = (len > YANK_CAPACITY) ? YANK_CAPACITY : len;
        for (j = 0; j < yank_cnt; j++) yank_mem[j] = text_mem[s+j];
        cut_bytes(s, len + 1);
      end
      default: begin
        if (text_len >= TEXT_CAPACITY) return 0;
        p = e;
        if (p < text_len && text_mem[p] == NEWLINE) p++;
        if (!insert_byte(p, NEWLINE)) return 0;
      end
    endcase
    dirty = 1;
    index_lines();
    return 1;
  endfunction

  function automatic status_t predict_status(logic [CMD_W-1:0] code, int ln, int col,
                                             logic [BYTE_W-1:0] ch, int off);
    status_t r;
    r = '0;
    case (code)
      CMD_CLEAR: begin
        text_len = 0;
        dirty = 0;
        index_lines();
        r.ok = 1;
      end
      CMD_APPEND: if (text_len < TEXT_CAPACITY) begin
        text_mem[text_len] = ch;
        text_len++;
        index_lines();
        r.ok = 1;
      end
      CMD_READ: if (off < text_len) begin
        r.byte_out = text_mem[off];
        r.ok = 1;
      end
      CMD_YREAD: if (off < yank_cnt) begin
        r.byte_out = yank_mem[off];
        r.ok = 1;
      end
      CMD_INS_CHAR, CMD_DEL_CHAR, CMD_SPLIT, CMD_JOIN, CMD_DEL_LINE, CMD_INS_LINE:
        r.ok = apply_edit(cmd_t'(code), ln, col, ch);
      default: ;
    endcase
    r.line_count  = LCNT_W'(n_lines);
    r.text_length = TLEN_W'(text_len);
    r.yank_length = YLEN_W'(yank_cnt);
    r.modified    = dirty;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    text_len   = 0;
    yank_cnt   = 0;
    n_lines    = 1;
    dirty      = 0;
    line_base[0] = 0;
  end

  always @(posedge clk) begin
    status_t want, got;
    if (rst_n) begin
      if (in_valid && in_ready)
        status_q.push_back(predict_status(in_command, int'(in_line_number),
                                          int'(in_column), in_char_in,
                                          int'(in_read_offset)));
      if (out_valid && out_ready) begin
        got = {out_ok, out_byte_out, out_line_count, out_text_length,
               out_yank_length, out_modified};
        if (status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = status_q.pop_front();
          if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

endmodule

### dv/line_indexed_text_buffer_core_test.sv
// Top of the text buffer testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module line_indexed_text_buffer_core_test;
  import ltb_pkg::*;

  localparam int STALL_LIMIT = 60000;

  logic              clk;
  logic              rst_n;
  logic              in_valid, in_ready;
  logic [CMD_W-1:0]  in_command;
  logic [LINE_W-1:0] in_line_number;
  logic [COL_W-1:0]  in_column;
  logic [BYTE_W-1:0] in_char_in;
  logic [OFF_W-1:0]  in_read_offset;
  logic              out_valid, out_ready, out_ok, out_modified;
  logic [BYTE_W-1:0] out_byte_out;
  logic [LCNT_W-1:0] out_line_count;
  logic [TLEN_W-1:0] out_text_length;
  logic [YLEN_W-1:0] out_yank_length;
  int                fail_count, pending;
  int                send_idle_pct, recv_stall_pct, hold_cycles, idle_cycles;

  line_indexed_text_buffer_core u_top (.*);

  ltb_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic issue(cmd_t cmd, int ln, int col, int ch, int off);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid       <= 1;
    in_command     <= cmd;
    in_line_number <= LINE_W'(ln);
    in_column      <= COL_W'(col);
    in_char_in     <= BYTE_W'(ch);
    in_read_offset <= OFF_W'(off);
    do @(posedge clk); while (!in_ready);
  endtask

  // unused command codes go out through a raw variant
  task automatic issue_raw(logic [CMD_W-1:0] code, int ln, int col, int ch, int off);
    issue(cmd_t'(code), ln, col, ch, off);
  endtask

  task automatic random_command();
    int pick, ln, col, ch, off;
    pick = $urandom_range(99);
    ln   = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(6);
    col  = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(8);
    ch   = ($urandom_range(2) == 0) ? NEWLINE : $urandom_range(255);
    off  = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(40);
    if (pick < 4)        issue(CMD_CLEAR, ln, col, ch, off);
    else if (pick < 30)  issue(CMD_APPEND, ln, col, ch, off);
    else if (pick < 38)  issue(CMD_READ, ln, col, ch, off);
    else if (pick < 43)  issue(CMD_YREAD, ln, col, ch, off);
    else if (pick < 55)  issue(CMD_INS_CHAR, ln, col, ch, off);
    else if (pick < 65)  issue(CMD_DEL_CHAR, ln, col, ch, off);
    else if (pick < 73)  issue(CMD_SPLIT, ln, col, ch, off);
    else if (pick < 80)  issue(CMD_JOIN, ln, col, ch, off);
    else if (pick < 88)  issue(CMD_DEL_LINE, ln, col, ch, off);
    else if (pick < 97)  issue(CMD_INS_LINE, ln, col, ch, off);
    else                 issue_raw(CMD_W'($urandom_range(15, 10)), ln, col, ch, off);
  endtask

  initial begin
    int i, ph, k, waited;
    rst_n = 0;
    in_valid = 0;
    in_command = CMD_CLEAR;
    in_line_number = 0;
    in_column = 0;
    in_char_in = 0;
    in_read_offset = 0;
    out_ready = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty buffer corners, then a small text worked over by every edit
    issue(CMD_READ, 0, 0, 0, 0);
    issue(CMD_YREAD, 0, 0, 0, 511);
    issue(CMD_JOIN, 0, 0, 0, 0);
    issue(CMD_DEL_LINE, 0, 0, 0, 0);
    issue(CMD_APPEND, 0, 0, 8'hFF, 0);
    issue(CMD_APPEND, 0, 0, 8'h00, 0);
    issue(CMD_APPEND, 0, 0, NEWLINE, 0);
    issue(CMD_APPEND, 0, 0, 8'h63, 0);
    issue(CMD_INS_CHAR, 1, 1, 8'h41, 0);
    issue(CMD_INS_CHAR, 1, 3, 8'h42, 0);
    issue(CMD_DEL_CHAR, 0, 2, 0, 0);
    issue(CMD_DEL_CHAR, 0, 0, 0, 0);
    issue(CMD_SPLIT, 0, 1, 0, 0);
    issue(CMD_SPLIT, 2, 255, 0, 0);
    issue(CMD_JOIN, 0, 0, 0, 0);
    issue(CMD_JOIN, 1, 0, 0, 0);
    issue(CMD_INS_LINE, 0, 0, 0, 0);
    issue(CMD_DEL_LINE, 2, 0, 0, 0);
    issue(CMD_YREAD, 0, 0, 0, 1);
    issue(CMD_READ, 0, 0, 0, 2);
    issue(CMD_DEL_LINE, 255, 0, 0, 0);
    issue_raw(4'hF, 255, 255, 255, 511);
    issue(CMD_CLEAR, 0, 0, 0, 0);
    issue(CMD_DEL_LINE, 0, 0, 0, 0);

    // fill the store with more lines than the table indexes, across the idling phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (ph == 0) hold_cycles <= 3000;
      for (i = 0; i < 128; i++) begin
        k = ph * 128 + i;
        issue(CMD_APPEND, 0, 0, (k % 6 == 5) ? NEWLINE : (k & 8'hFF) ^ 8'h55, 0);
      end
    end
    issue(CMD_APPEND, 0, 0, 1, 0);
    issue(CMD_INS_CHAR, 0, 0, 1, 0);
    issue(CMD_SPLIT, 1, 1, 0, 0);
    issue(CMD_INS_LINE, 63, 0, 0, 0);
    issue(CMD_DEL_CHAR, 63, 2, 0, 0);
    issue(CMD_READ, 0, 0, 0, 511);
    issue(CMD_DEL_LINE, 64, 0, 0, 0);
    issue(CMD_JOIN, 63, 0, 0, 0);
    issue(CMD_DEL_LINE, 10, 0, 0, 0);
    issue(CMD_SPLIT, 62, 5, 0, 0);
    for (i = 0; i < 16; i++) random_command();
    issue(CMD_CLEAR, 0, 0, 0, 0);
    in_valid <= 0;

    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < STALL_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### line_indexed_text_buffer_core.f
+incdir+src
src/ltb_pkg.sv
src/ltb_ram.sv
src/line_indexed_text_buffer_core.sv
dv/ltb_checker.sv
dv/line_indexed_text_buffer_core_test.sv
